// ===== src/ssig_pkg.sv =====
`timescale 1ns / 1ps

package ssig_pkg;

    localparam int SIG_COUNT = 5;
    localparam int WIN_LEN   = 8;
    localparam int BYTE_W    = 8;
    localparam int RUN_W     = 8;
    localparam int MIN_LEN   = 4;

    localparam logic [BYTE_W-1:0] NOP_BYTE      = 8'h90;
    localparam logic [RUN_W-1:0]  NOP_LIMIT_RST = 8'd16;
    localparam logic [RUN_W-1:0]  RUN_MAX       = {RUN_W{1'b1}};

    typedef logic [SIG_COUNT-1:0] t_sig_vec;

    typedef struct packed {
        logic hit;
        logic is_nop;
        logic long_enough;
        logic last;
    } t_scan_status;

    localparam int SIG_LEN [SIG_COUNT] = '{8, 4, 5, 3, 6};

    localparam logic [BYTE_W-1:0] SIG_BYTES [SIG_COUNT][WIN_LEN] = '{
        '{8'h48, 8'h31, 8'hd2, 8'h48, 8'h31, 8'hf6, 8'h48, 8'hbb},
        '{8'h31, 8'hc0, 8'h50, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h89, 8'hc7, 8'h0f, 8'h05, 8'h00, 8'h00, 8'h00},
        '{8'h31, 8'hc0, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6a, 8'h29, 8'h58, 8'h99, 8'h6a, 8'h02, 8'h00, 8'h00}
    };

endpackage

// ===== src/ssig_cell.sv =====
`timescale 1ns / 1ps

module ssig_cell #(
    parameter int POS = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_shift,
    input  logic [ssig_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_valid,
    output logic [ssig_pkg::BYTE_W-1:0]  o_byte,
    output logic                         o_valid,
    output ssig_pkg::t_sig_vec           o_match
);
    import ssig_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic              r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    for (genvar s = 0; s < SIG_COUNT; s++) begin : g_sig
        localparam int LEN = SIG_LEN[s];
        if (POS >= LEN) begin : g_free
            assign o_match[s] = 1'b1;
        end else begin : g_cmp
            assign o_match[s] = r_valid && (r_byte == SIG_BYTES[s][LEN-1-POS]);
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// ===== src/ssig_eval.sv =====
`timescale 1ns / 1ps

module ssig_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pending,
    input  ssig_pkg::t_scan_status      i_status,
    input  logic                        i_cfg_wr_en,
    input  logic [ssig_pkg::RUN_W-1:0]  i_cfg_wr_data,
    input  logic                        i_out_ready,
    output logic                        o_eval_go,
    output logic                        o_out_valid,
    output logic                        o_out_detected
);
    import ssig_pkg::*;

    logic [RUN_W-1:0] r_limit;
    logic [RUN_W-1:0] r_nop_run;
    logic [RUN_W-1:0] n_nop_run;
    logic             r_found;
    logic             n_found;
    logic             r_out_valid;
    logic             r_out_det;
    logic             w_sled;
    logic             w_out_free;

    always_comb begin
        n_nop_run = (r_nop_run == RUN_MAX) ? r_nop_run : r_nop_run + 1'b1;
        w_sled    = i_status.is_nop && (n_nop_run >= r_limit);
        n_found   = r_found || i_status.hit || w_sled;
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_eval_go  = i_pending && (!i_status.last || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= NOP_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nop_run   <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_eval_go && i_status.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_eval_go) begin
                if (i_status.last) begin
                    r_nop_run <= '0;
                    r_found   <= 1'b0;
                end else begin
                    r_nop_run <= i_status.is_nop ? n_nop_run : '0;
                    r_found   <= n_found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_eval_go && i_status.last) begin
            r_out_det <= n_found && i_status.long_enough;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_detected = r_out_det;

endmodule

// ===== src/shellcode_signature_scanner.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                      Contents
// s_axis    in         tvalid tready tdata tlast    tdata[7:0] data_byte, tlast last_byte
// m_axis    out        tvalid tready tdata          tdata[0] detected, [7:1] zero
// cfg       in         wr_en wr_data                wr_data[7:0] nop_run_limit
//
// One byte per cycle unless a verdict is stalled; a byte enters the eight-cell shift
// chain on acceptance and is checked against all signatures in the following cycle.
// The verdict is registered at the output when the head cell's last byte is evaluated.
// Reset is synchronous: chain valid bits, counters and the output clear at once.
// A stalled output holds the input only when the next verdict is due.
module shellcode_signature_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] detected, [7:1] zero
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);
    import ssig_pkg::*;

    logic [BYTE_W-1:0] w_byte  [WIN_LEN];
    logic              w_valid [WIN_LEN];
    t_sig_vec          w_match [WIN_LEN];
    t_sig_vec          w_sig_hit;
    t_scan_status      w_status;
    logic              w_accept;
    logic              w_eval_go;
    logic              w_out_det;
    logic              r_new;
    logic              r_last0;

    assign o_s_axis_tready = !r_new || w_eval_go;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new <= 1'b0;
        end else if (w_accept) begin
            r_new <= 1'b1;
        end else if (w_eval_go) begin
            r_new <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last0 <= 1'b0;
        end else if (w_accept) begin
            r_last0 <= i_s_axis_tlast;
        end
    end

    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        logic [BYTE_W-1:0] w_in_byte;
        logic              w_in_valid;
        if (k == 0) begin : g_head
            assign w_in_byte  = i_s_axis_tdata;
            assign w_in_valid = 1'b1;
        end else begin : g_body
            assign w_in_byte  = w_byte[k-1];
            assign w_in_valid = w_valid[k-1] && !r_last0;
        end
        ssig_cell #(
            .POS(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_byte  (w_in_byte),
            .i_valid (w_in_valid),
            .o_byte  (w_byte[k]),
            .o_valid (w_valid[k]),
            .o_match (w_match[k])
        );
    end

    always_comb begin
        w_sig_hit = '1;
        for (int k = 0; k < WIN_LEN; k++) begin
            w_sig_hit = w_sig_hit & w_match[k];
        end
        w_status.hit         = |w_sig_hit;
        w_status.is_nop      = (w_byte[0] == NOP_BYTE);
        w_status.long_enough = w_valid[MIN_LEN-1];
        w_status.last        = r_last0;
    end

    ssig_eval u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pending      (r_new),
        .i_status       (w_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_out_ready    (i_m_axis_tready),
        .o_eval_go      (w_eval_go),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_detected (w_out_det)
    );

    assign o_m_axis_tdata = {7'd0, w_out_det};

endmodule
